FILE: rtl/segx_pkg.sv
// Shared constants, term tables and flag types for the segment intersection pipeline.
// Depends on nothing; every other file in rtl imports it.
package segx_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_FIELDS      = 8;
  localparam int NUM_POINTS      = 4;
  localparam int OUT_TDATA_W     = 8;

  // Point indexes within the input transaction.
  localparam int PT_A = 0;
  localparam int PT_B = 1;
  localparam int PT_C = 2;
  localparam int PT_D = 3;

  // Coordinate differences formed in the first stage.
  localparam int NUM_DIFFS = 6;
  localparam int DIFF_AB   = 0;
  localparam int DIFF_AC   = 1;
  localparam int DIFF_AD   = 2;
  localparam int DIFF_BC   = 3;
  localparam int DIFF_BD   = 4;
  localparam int DIFF_CD   = 5;

  localparam int DIFF_P [NUM_DIFFS] = '{PT_A, PT_A, PT_A, PT_B, PT_B, PT_C};
  localparam int DIFF_Q [NUM_DIFFS] = '{PT_B, PT_C, PT_D, PT_C, PT_D, PT_D};

  // Cross and dot products of pairs of differences.
  localparam int NUM_TERMS   = 8;
  localparam int TERM_XAB_BD = 0;
  localparam int TERM_XAB_BC = 1;
  localparam int TERM_XCD_AD = 2;
  localparam int TERM_XCD_BD = 3;
  localparam int TERM_DOT_A  = 4;
  localparam int TERM_DOT_B  = 5;
  localparam int TERM_DOT_C  = 6;
  localparam int TERM_DOT_D  = 7;

  localparam int TERM_U [NUM_TERMS] = '{DIFF_AB, DIFF_AB, DIFF_CD, DIFF_CD,
                                        DIFF_AC, DIFF_BC, DIFF_AC, DIFF_AD};
  localparam int TERM_V [NUM_TERMS] = '{DIFF_BD, DIFF_BC, DIFF_AD, DIFF_BD,
                                        DIFF_AD, DIFF_BD, DIFF_BC, DIFF_BD};
  localparam bit TERM_IS_DOT [NUM_TERMS] = '{1'b0, 1'b0, 1'b0, 1'b0,
                                             1'b1, 1'b1, 1'b1, 1'b1};

  typedef struct packed {
    logic [NUM_TERMS-1:0] zero;
    logic [NUM_TERMS-1:0] neg;
  } term_flags_t;

endpackage

FILE: rtl/segx_diff.sv
// First pipeline stage: unpacks the four points and registers their pairwise differences.
// Depends on segx_pkg.
module segx_diff #(
  parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [segx_pkg::NUM_FIELDS*COORD_WIDTH-1:0]  in_data,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic signed [COORD_WIDTH:0]                  out_dx [segx_pkg::NUM_DIFFS],
  output logic signed [COORD_WIDTH:0]                  out_dy [segx_pkg::NUM_DIFFS]
);
  import segx_pkg::*;

  logic                        valid_r;
  logic signed [COORD_WIDTH:0] px [NUM_POINTS];
  logic signed [COORD_WIDTH:0] py [NUM_POINTS];
  logic signed [COORD_WIDTH:0] dx_nxt [NUM_DIFFS];
  logic signed [COORD_WIDTH:0] dy_nxt [NUM_DIFFS];
  logic signed [COORD_WIDTH:0] dx_r [NUM_DIFFS];
  logic signed [COORD_WIDTH:0] dy_r [NUM_DIFFS];

  for (genvar p = 0; p < NUM_POINTS; p++) begin : g_pt
    assign px[p] = {in_data[(2*p+1)*COORD_WIDTH-1], in_data[2*p*COORD_WIDTH +: COORD_WIDTH]};
    assign py[p] = {in_data[(2*p+2)*COORD_WIDTH-1],
                    in_data[(2*p+1)*COORD_WIDTH +: COORD_WIDTH]};
  end

  for (genvar i = 0; i < NUM_DIFFS; i++) begin : g_diff
    assign dx_nxt[i] = px[DIFF_P[i]] - px[DIFF_Q[i]];
    assign dy_nxt[i] = py[DIFF_P[i]] - py[DIFF_Q[i]];
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_dx    = dx_r;
  assign out_dy    = dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

endmodule

FILE: rtl/segx_mul.sv
// Second pipeline stage: registers the two partial products of every cross and dot term.
// Depends on segx_pkg.
module segx_mul #(
  parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH:0]       in_dx [segx_pkg::NUM_DIFFS],
  input  logic signed [COORD_WIDTH:0]       in_dy [segx_pkg::NUM_DIFFS],
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [2*COORD_WIDTH+1:0]   out_pl [segx_pkg::NUM_TERMS],
  output logic signed [2*COORD_WIDTH+1:0]   out_pr [segx_pkg::NUM_TERMS]
);
  import segx_pkg::*;

  localparam int PW = 2*COORD_WIDTH + 2;

  logic                 valid_r;
  logic signed [PW-1:0] pl_nxt [NUM_TERMS];
  logic signed [PW-1:0] pr_nxt [NUM_TERMS];
  logic signed [PW-1:0] pl_r [NUM_TERMS];
  logic signed [PW-1:0] pr_r [NUM_TERMS];

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    if (TERM_IS_DOT[k]) begin : g_dot
      assign pl_nxt[k] = in_dx[TERM_U[k]] * in_dx[TERM_V[k]];
      assign pr_nxt[k] = in_dy[TERM_U[k]] * in_dy[TERM_V[k]];
    end else begin : g_cross
      assign pl_nxt[k] = in_dx[TERM_U[k]] * in_dy[TERM_V[k]];
      assign pr_nxt[k] = in_dy[TERM_U[k]] * in_dx[TERM_V[k]];
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_pl    = pl_r;
  assign out_pr    = pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pl_r <= pl_nxt;
      pr_r <= pr_nxt;
    end
  end

endmodule

FILE: rtl/segx_sum.sv
// Third pipeline stage: completes each term and registers its zero and sign flags.
// Depends on segx_pkg.
module segx_sum #(
  parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [2*COORD_WIDTH+1:0]   in_pl [segx_pkg::NUM_TERMS],
  input  logic signed [2*COORD_WIDTH+1:0]   in_pr [segx_pkg::NUM_TERMS],
  output logic                              out_valid,
  input  logic                              out_ready,
  output segx_pkg::term_flags_t             out_flags
);
  import segx_pkg::*;

  localparam int PW = 2*COORD_WIDTH + 2;
  localparam int SW = PW + 1;

  logic                 valid_r;
  logic signed [SW-1:0] term_sum [NUM_TERMS];
  term_flags_t          flags_nxt;
  term_flags_t          flags_r;

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    if (TERM_IS_DOT[k]) begin : g_dot
      assign term_sum[k] = {in_pl[k][PW-1], in_pl[k]} + {in_pr[k][PW-1], in_pr[k]};
    end else begin : g_cross
      assign term_sum[k] = {in_pl[k][PW-1], in_pl[k]} - {in_pr[k][PW-1], in_pr[k]};
    end
    assign flags_nxt.zero[k] = (term_sum[k] == '0);
    assign flags_nxt.neg[k]  = term_sum[k][SW-1];
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_flags = flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

FILE: rtl/segx_eval.sv
// Final pipeline stage: combines the term flags into the two verdicts and holds the output.
// Depends on segx_pkg.
module segx_eval (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  segx_pkg::term_flags_t              in_flags,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [segx_pkg::OUT_TDATA_W-1:0]   out_data
);
  import segx_pkg::*;

  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r;
  logic [OUT_TDATA_W-1:0] data_nxt;
  logic                   split_cd;
  logic                   split_ab;
  logic                   proper;
  logic                   on_a;
  logic                   on_b;
  logic                   on_c;
  logic                   on_d;
  logic                   touches;

  // C and D lie strictly on opposite sides of line AB, and A and B of line CD.
  assign split_cd = !in_flags.zero[TERM_XAB_BD] && !in_flags.zero[TERM_XAB_BC] &&
                    (in_flags.neg[TERM_XAB_BD] != in_flags.neg[TERM_XAB_BC]);
  assign split_ab = !in_flags.zero[TERM_XCD_AD] && !in_flags.zero[TERM_XCD_BD] &&
                    (in_flags.neg[TERM_XCD_AD] != in_flags.neg[TERM_XCD_BD]);
  assign proper   = split_cd && split_ab;

  // An endpoint touches the other segment when collinear with it and between its ends.
  assign on_a = in_flags.zero[TERM_XCD_AD] &&
                (in_flags.zero[TERM_DOT_A] || in_flags.neg[TERM_DOT_A]);
  assign on_b = in_flags.zero[TERM_XCD_BD] &&
                (in_flags.zero[TERM_DOT_B] || in_flags.neg[TERM_DOT_B]);
  assign on_c = in_flags.zero[TERM_XAB_BC] &&
                (in_flags.zero[TERM_DOT_C] || in_flags.neg[TERM_DOT_C]);
  assign on_d = in_flags.zero[TERM_XAB_BD] &&
                (in_flags.zero[TERM_DOT_D] || in_flags.neg[TERM_DOT_D]);
  assign touches = on_a || on_b || on_c || on_d;

  assign data_nxt = {{(OUT_TDATA_W-2){1'b0}}, proper || touches, proper};

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: rtl/segment_intersection_test.sv
// Top level of the segment intersection test: four pipeline stages in a chain.
// Depends on segx_pkg, segx_diff, segx_mul, segx_sum and segx_eval.
//
// Each input transaction carries the endpoints of segments AB and CD as signed fixed-point
// coordinates; each output transaction reports whether they cross properly and whether
// they meet at all. The arithmetic is exact, so the verdicts never depend on rounding.
// The pipeline has four register stages: coordinate differences, partial products,
// term sums with their zero and sign flags, and the output register with the verdicts.
// A transaction accepted into the difference register passes through the partial-product,
// flag and output registers before it is presented on the output channel. While the receiver
// takes the output, a new transaction can be accepted on every cycle, so the sustained rate is
// one item per cycle; the multiplier stage sets the depth of the critical path.
// Every stage has its own valid bit and takes new data whenever it is empty or its
// successor takes its contents, so a stall of the receiver holds the results in place
// and bubbles still close up; in_tready falls only once all four stages are full.
// Synchronous reset empties all stages; no transaction is lost or repeated on a stall.
module segment_intersection_test #(
  parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // Fields from the lowest bit: a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y.
  input  logic [segx_pkg::NUM_FIELDS*COORD_WIDTH-1:0]  in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // Fields from the lowest bit: crosses_properly, intersects, zero fill.
  output logic [segx_pkg::OUT_TDATA_W-1:0]             out_tdata
);
  import segx_pkg::*;

  logic                          diff_valid;
  logic                          diff_ready;
  logic signed [COORD_WIDTH:0]   diff_dx [NUM_DIFFS];
  logic signed [COORD_WIDTH:0]   diff_dy [NUM_DIFFS];
  logic                          mul_valid;
  logic                          mul_ready;
  logic signed [2*COORD_WIDTH+1:0] mul_pl [NUM_TERMS];
  logic signed [2*COORD_WIDTH+1:0] mul_pr [NUM_TERMS];
  logic                          sum_valid;
  logic                          sum_ready;
  term_flags_t                   sum_flags;

  segx_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (diff_valid),
    .out_ready (diff_ready),
    .out_dx    (diff_dx),
    .out_dy    (diff_dy)
  );

  segx_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (diff_valid),
    .in_ready  (diff_ready),
    .in_dx     (diff_dx),
    .in_dy     (diff_dy),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_pl    (mul_pl),
    .out_pr    (mul_pr)
  );

  segx_sum #(.COORD_WIDTH(COORD_WIDTH)) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_pl     (mul_pl),
    .in_pr     (mul_pr),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_flags (sum_flags)
  );

  segx_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_flags  (sum_flags),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
